// ===== design/gtab_pkg.sv =====
// shared types and constants of the generation handle group table
`timescale 1ns / 1ps

package gtab_pkg;

  localparam int GROUPS     = 16;
  localparam int MEMBER_CAP = 16;
  localparam int SLOT_W     = 4;
  localparam int IDX_W      = 4;
  localparam int TOT_W      = 5;
  localparam int MEM_AW     = SLOT_W + IDX_W;
  localparam int MEM_DEPTH  = GROUPS * MEMBER_CAP;
  localparam int IN_W       = 104;
  localparam int OUT_W      = 208;

  typedef enum logic [1:0] {
    ST_RETIRED = 2'd0,
    ST_OPEN    = 2'd1,
    ST_EXITING = 2'd2
  } row_state_t;

  typedef enum logic [2:0] {
    OP_CREATE     = 3'd0,
    OP_RETAIN     = 3'd1,
    OP_RELEASE    = 3'd2,
    OP_ATTACH     = 3'd3,
    OP_DETACH     = 3'd4,
    OP_BEGIN_EXIT = 3'd5,
    OP_INSPECT    = 3'd6,
    OP_UNUSED     = 3'd7
  } opcode_t;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_REJECT  = 2'd1,
    STS_ALREADY = 2'd2
  } status_t;

  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

  // one row of group metadata
  typedef struct packed {
    row_state_t       st;
    logic [31:0]      gen;
    logic [31:0]      cnt;
    logic [63:0]      leader;
    logic [TOT_W-1:0] tot;
  } meta_t;

  localparam int META_W = $bits(meta_t);

  typedef struct packed {
    logic [63:0]       member_value;
    logic [TOT_W-1:0]  members_in_use;
    logic [63:0]       leader_identity;
    logic [31:0]       owner_count;
    logic [1:0]        group_state;
    logic [31:0]       out_generation;
    logic [SLOT_W-1:0] out_slot;
    status_t           status;
  } result_t;

endpackage

// ===== design/generation_handle_group_table.sv =====
// top level of the generation handle group table
//
//  channel   | signals                     | payload
//  ----------+-----------------------------+----------------------------------------
//  s_axis    | tvalid tready tdata         | opcode slot handle_generation identity
//  m_axis    | tvalid tready tdata tlast   | result fields, tlast marks the final item
//  cfg       | cfg_valid cfg_ready cfg_data| generation_ceiling
//
//  create scans the metadata ram one row a cycle; a zero leader is rejected without a scan.
//  attach and detach walk the member ram one entry a cycle.
//  inspect reads each member entry in S_IRD and sends it in S_IOUT; other items give one result.
//  reset clears the row valid bits at once, so no clearing pass is needed.
//  a result waits in the output register while the next item is taken.
`timescale 1ns / 1ps

module generation_handle_group_table (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // opcode[2:0] slot[6:3] handle_generation[38:7] identity[102:39], zero pad
  input  logic [gtab_pkg::IN_W-1:0]    s_tdata,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // status[1:0] out_slot[5:2] out_generation[37:6] group_state[39:38]
  // owner_count[71:40] leader_identity[135:72] members_in_use[140:136]
  // member_value[204:141], zero pad
  output logic [gtab_pkg::OUT_W-1:0]   m_tdata,
  output logic                         m_tlast,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [31:0]                  cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_CEV, S_MEV, S_WEV, S_AEND, S_DEND, S_IRD, S_IOUT, S_RES
  } fsm_t;

  fsm_t                         state;
  gtab_pkg::opcode_t            op;
  logic [gtab_pkg::SLOT_W-1:0]  slot;
  logic [31:0]                  hgen;
  logic [63:0]                  id;
  logic [gtab_pkg::SLOT_W-1:0]  row;
  logic [gtab_pkg::TOT_W-1:0]   i;
  logic [gtab_pkg::TOT_W-1:0]   n;
  logic                         flag;
  logic [63:0]                  held;
  gtab_pkg::meta_t              mrow;
  gtab_pkg::result_t            res;
  gtab_pkg::result_t            out_res;
  logic                         out_last;
  logic                         out_valid;
  logic [31:0]                  ceiling;
  logic [gtab_pkg::GROUPS-1:0]  meta_valid;
  logic                         mv_q;

  logic                         meta_we, meta_re;
  logic [gtab_pkg::SLOT_W-1:0]  meta_wa, meta_ra;
  gtab_pkg::meta_t              meta_wd, meta_rd, meta_cur;
  logic                         mem_we, mem_re;
  logic [gtab_pkg::MEM_AW-1:0]  mem_wa, mem_ra;
  logic [63:0]                  mem_wd, mem_rd;

  logic resolved, active, cand;
  logic retain_ok, release_ok, exit_ok, attach_ok, detach_ok;
  logic a_dup, a_place, d_hit, last_pos, out_free, out_load;
  logic [gtab_pkg::TOT_W-1:0] i_inc;
  gtab_pkg::result_t res_init, inspect_res;

  gtab_pkg::opcode_t in_op;
  logic [gtab_pkg::SLOT_W-1:0] in_slot;

  assign in_op   = gtab_pkg::opcode_t'(s_tdata[2:0]);
  assign in_slot = s_tdata[6:3];

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign m_tvalid  = out_valid;
  assign m_tdata   = {{(gtab_pkg::OUT_W - $bits(gtab_pkg::result_t)){1'b0}}, out_res};
  assign m_tlast   = out_last;
  assign out_free  = !out_valid || m_tready;
  assign out_load  = ((state == S_RES) && out_free) || (state == S_IOUT);

  gtab_ram #(.WIDTH(gtab_pkg::META_W), .DEPTH(gtab_pkg::GROUPS)) u_meta (
    .clk(clk), .we(meta_we), .waddr(meta_wa), .wdata(meta_wd),
    .re(meta_re), .raddr(meta_ra), .rdata(meta_rd)
  );

  gtab_ram #(.WIDTH(64), .DEPTH(gtab_pkg::MEM_DEPTH)) u_members (
    .clk(clk), .we(mem_we), .waddr(mem_wa), .wdata(mem_wd),
    .re(mem_re), .raddr(mem_ra), .rdata(mem_rd)
  );

  // a row never written reads as its reset value
  assign meta_cur = mv_q ? meta_rd : '0;

  always_comb begin
    i_inc     = i + gtab_pkg::TOT_W'(1);
    last_pos  = (i_inc == n);
    resolved  = (hgen != 32'd0) && (meta_cur.gen == hgen);
    active    = ((meta_cur.st == gtab_pkg::ST_OPEN) || (meta_cur.st == gtab_pkg::ST_EXITING))
                && (meta_cur.cnt != 32'd0);
    cand      = (meta_cur.st == gtab_pkg::ST_RETIRED) && (meta_cur.gen < ceiling);
    retain_ok = resolved && active && (meta_cur.cnt != gtab_pkg::COUNT_MAX);
    release_ok = resolved && active &&
                 !((meta_cur.cnt == 32'd1) &&
                   ((meta_cur.st != gtab_pkg::ST_EXITING) || (meta_cur.tot != '0)));
    exit_ok   = resolved && active;
    attach_ok = (id != 64'd0) && resolved && (meta_cur.st == gtab_pkg::ST_OPEN) &&
                (meta_cur.cnt != 32'd0) &&
                (meta_cur.tot < gtab_pkg::TOT_W'(gtab_pkg::MEMBER_CAP));
    detach_ok = (id != 64'd0) && resolved && active;
    a_dup     = !flag && (mem_rd == id);
    a_place   = !flag && (mem_rd > id);
    d_hit     = !flag && (mem_rd == id);

    res_init        = '0;
    res_init.status = gtab_pkg::STS_REJECT;

    inspect_res                 = '0;
    inspect_res.status          = gtab_pkg::STS_OK;
    inspect_res.group_state     = mrow.st;
    inspect_res.owner_count     = mrow.cnt;
    inspect_res.leader_identity = mrow.leader;
    inspect_res.members_in_use  = mrow.tot;
    // entries past the fill count always read as empty
    inspect_res.member_value    = (i < mrow.tot) ? mem_rd : 64'd0;

    meta_we = 1'b0;
    meta_wa = slot;
    meta_wd = meta_cur;
    meta_re = 1'b0;
    meta_ra = row;
    mem_we  = 1'b0;
    mem_wa  = {slot, i[gtab_pkg::IDX_W-1:0]};
    mem_wd  = '0;
    mem_re  = 1'b0;
    mem_ra  = {slot, i[gtab_pkg::IDX_W-1:0]};

    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          meta_re = 1'b1;
          meta_ra = (in_op == gtab_pkg::OP_CREATE) ? '0 : in_slot;
        end
      end
      S_CEV: begin
        if (cand) begin
          meta_we        = 1'b1;
          meta_wa        = row;
          meta_wd.st     = gtab_pkg::ST_OPEN;
          meta_wd.gen    = meta_cur.gen + 32'd1;
          meta_wd.cnt    = 32'd1;
          meta_wd.leader = id;
          meta_wd.tot    = gtab_pkg::TOT_W'(1);
          mem_we         = 1'b1;
          mem_wa         = {row, {gtab_pkg::IDX_W{1'b0}}};
          mem_wd         = id;
        end else if (row != gtab_pkg::SLOT_W'(gtab_pkg::GROUPS - 1)) begin
          meta_re = 1'b1;
          meta_ra = row + gtab_pkg::SLOT_W'(1);
        end
      end
      S_MEV: begin
        case (op)
          gtab_pkg::OP_RETAIN: begin
            meta_we     = retain_ok;
            meta_wd.cnt = meta_cur.cnt + 32'd1;
          end
          gtab_pkg::OP_RELEASE: begin
            meta_we     = release_ok;
            meta_wd.cnt = meta_cur.cnt - 32'd1;
            if (meta_cur.cnt == 32'd1) begin
              meta_wd.st = gtab_pkg::ST_RETIRED;
            end
          end
          gtab_pkg::OP_BEGIN_EXIT: begin
            meta_we    = exit_ok && (meta_cur.st != gtab_pkg::ST_EXITING);
            meta_wd.st = gtab_pkg::ST_EXITING;
          end
          gtab_pkg::OP_ATTACH: begin
            mem_re = attach_ok && (meta_cur.tot != '0);
            mem_ra = {slot, {gtab_pkg::IDX_W{1'b0}}};
          end
          gtab_pkg::OP_DETACH: begin
            mem_re = detach_ok && (meta_cur.tot != '0);
            mem_ra = {slot, {gtab_pkg::IDX_W{1'b0}}};
          end
          default: begin
          end
        endcase
      end
      S_WEV: begin
        mem_re = !last_pos;
        mem_ra = {slot, i_inc[gtab_pkg::IDX_W-1:0]};
        if (op == gtab_pkg::OP_ATTACH) begin
          if (flag) begin
            mem_we = 1'b1;
            mem_wd = held;
          end else if (a_place) begin
            mem_we = 1'b1;
            mem_wd = id;
          end
          if (a_dup) begin
            mem_re = 1'b0;
          end
        end else if (flag) begin
          // close the gap left by the removed member
          mem_we = 1'b1;
          mem_wa = {slot, (i[gtab_pkg::IDX_W-1:0] - gtab_pkg::IDX_W'(1))};
          mem_wd = mem_rd;
        end
      end
      S_AEND: begin
        mem_we      = 1'b1;
        mem_wa      = {slot, n[gtab_pkg::IDX_W-1:0]};
        mem_wd      = flag ? held : id;
        meta_we     = 1'b1;
        meta_wd     = mrow;
        meta_wd.tot = n + gtab_pkg::TOT_W'(1);
      end
      S_DEND: begin
        mem_we      = 1'b1;
        mem_wa      = {slot, (n[gtab_pkg::IDX_W-1:0] - gtab_pkg::IDX_W'(1))};
        mem_wd      = '0;
        meta_we     = 1'b1;
        meta_wd     = mrow;
        meta_wd.tot = n - gtab_pkg::TOT_W'(1);
      end
      S_IRD: begin
        mem_re = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      ceiling    <= 32'hFFFF_FFFF;
      meta_valid <= '0;
      mv_q       <= 1'b0;
    end else begin
      if (cfg_valid) begin
        ceiling <= cfg_data;
      end
      if (meta_re) begin
        mv_q <= meta_valid[meta_ra];
      end
      if (meta_we) begin
        meta_valid[meta_wa] <= 1'b1;
      end
      if (out_valid && m_tready && !out_load) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op   <= in_op;
            slot <= in_slot;
            hgen <= s_tdata[38:7];
            id   <= s_tdata[102:39];
            row  <= '0;
            res  <= res_init;
            if (in_op == gtab_pkg::OP_CREATE) begin
              state <= (s_tdata[102:39] == 64'd0) ? S_RES : S_CEV;
            end else if (in_op == gtab_pkg::OP_UNUSED) begin
              state <= S_RES;
            end else begin
              state <= S_MEV;
            end
          end
        end
        S_CEV: begin
          if (cand) begin
            res.status         <= gtab_pkg::STS_OK;
            res.out_slot       <= row;
            res.out_generation <= meta_cur.gen + 32'd1;
            state              <= S_RES;
          end else if (row == gtab_pkg::SLOT_W'(gtab_pkg::GROUPS - 1)) begin
            state <= S_RES;
          end else begin
            row <= row + gtab_pkg::SLOT_W'(1);
          end
        end
        S_MEV: begin
          mrow <= meta_cur;
          n    <= meta_cur.tot;
          i    <= '0;
          flag <= 1'b0;
          case (op)
            gtab_pkg::OP_RETAIN: begin
              if (retain_ok) res.status <= gtab_pkg::STS_OK;
              state <= S_RES;
            end
            gtab_pkg::OP_RELEASE: begin
              if (release_ok) res.status <= gtab_pkg::STS_OK;
              state <= S_RES;
            end
            gtab_pkg::OP_BEGIN_EXIT: begin
              if (exit_ok) begin
                res.status <= (meta_cur.st == gtab_pkg::ST_EXITING) ?
                              gtab_pkg::STS_ALREADY : gtab_pkg::STS_OK;
              end
              state <= S_RES;
            end
            gtab_pkg::OP_ATTACH: begin
              if (!attach_ok) begin
                state <= S_RES;
              end else begin
                state <= (meta_cur.tot == '0) ? S_AEND : S_WEV;
              end
            end
            gtab_pkg::OP_DETACH: begin
              if (detach_ok && (meta_cur.tot != '0)) begin
                state <= S_WEV;
              end else begin
                if (detach_ok) res.status <= gtab_pkg::STS_ALREADY;
                state <= S_RES;
              end
            end
            gtab_pkg::OP_INSPECT: begin
              state <= resolved ? S_IRD : S_RES;
            end
            default: begin
              state <= S_RES;
            end
          endcase
        end
        S_WEV: begin
          i <= i_inc;
          if (op == gtab_pkg::OP_ATTACH) begin
            if (flag) begin
              held <= mem_rd;
            end else if (a_place) begin
              held <= mem_rd;
              flag <= 1'b1;
            end
            if (a_dup) begin
              state <= S_RES;
            end else if (last_pos) begin
              state <= S_AEND;
            end
          end else begin
            if (d_hit) begin
              flag <= 1'b1;
            end
            if (last_pos) begin
              if (flag || d_hit) begin
                state <= S_DEND;
              end else begin
                res.status <= gtab_pkg::STS_ALREADY;
                state      <= S_RES;
              end
            end
          end
        end
        S_AEND, S_DEND: begin
          res.status <= gtab_pkg::STS_OK;
          state      <= S_RES;
        end
        S_IRD: begin
          if (out_free) begin
            state <= S_IOUT;
          end
        end
        S_IOUT: begin
          out_valid <= 1'b1;
          out_res   <= inspect_res;
          out_last  <= (i == gtab_pkg::TOT_W'(gtab_pkg::MEMBER_CAP - 1));
          i         <= i_inc;
          state <= (i == gtab_pkg::TOT_W'(gtab_pkg::MEMBER_CAP - 1)) ? S_IDLE : S_IRD;
        end
        S_RES: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_res   <= res;
            out_last  <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/gtab_ram.sv =====
// generic single write port, single read port ram with registered read data
`timescale 1ns / 1ps

module gtab_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
